// File: src/prefix_rule_lpm_table_top_defines.svh
// ----------------------------------------------------------------------------
// prefix rule lpm table assertion macros
// shared assertion shorthands for the rule table checker
// ----------------------------------------------------------------------------
`ifndef PREFIX_RULE_LPM_TABLE_TOP_DEFINES_SVH
`define PREFIX_RULE_LPM_TABLE_TOP_DEFINES_SVH

// same-cycle implication
`define PLT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plt assertion failed");

// next-cycle implication
`define PLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plt assertion failed");

`endif

// File: src/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// types, codes and helpers shared by the prefix rule table modules
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_BITS        = 32;
   localparam logic [5:0] MAX_V4_LEN = 6'd32;
   localparam logic [7:0] MAX_V6_LEN = 8'd128;

   typedef enum logic [1:0] {
      KIND_LOOKUP = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_FLUSH  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_LEN   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_COMMIT
   } state_type;

   // mapping data carried by a rule
   typedef struct packed {
      logic [63:0] v6_high;
      logic [63:0] v6_low;
      logic [7:0]  v6_length;
      logic [15:0] ratio;
      logic [15:0] adjacent;
      logic [7:0]  format;
      logic [7:0]  transport;
      logic [7:0]  extension;
   } rule_data_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] prefix;
      logic [5:0]          length;
      rule_data_type       data;
   } entry_type;

   typedef struct packed {
      logic load;
      logic read;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic last_read;
   } stat_type;

   function automatic logic [KEY_BITS-1:0] len_mask(input logic [5:0] len);
      logic [KEY_BITS-1:0] m;
      if (len >= MAX_V4_LEN) m = '1;
      else m = ~({KEY_BITS{1'b1}} >> len);
      return m;
   endfunction

endpackage

// File: src/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// sequencer: accept, scan the table, commit and present the response
// ----------------------------------------------------------------------------
module plt_ctrl
   import plt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_SCAN;
         S_SCAN:   if (stat.last_read) state_in = S_DRAIN;
         S_DRAIN:  state_in = S_COMMIT;
         S_COMMIT: if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_SCAN:   cmd.read   = 1'b1;
         S_DRAIN:  cmd        = '0;
         S_COMMIT: cmd.commit = out_free;
         default:  cmd        = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: src/plt_datapath.sv
// ----------------------------------------------------------------------------
// plt_datapath
// rule memory, valid bits, scan compare and response registers
// ----------------------------------------------------------------------------
module plt_datapath
   import plt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [1:0]          in_kind,
   input  logic [KEY_BITS-1:0] in_address,
   input  logic [5:0]          in_prefix_length,
   input  rule_data_type       in_data,
   output logic [1:0]          out_status,
   output logic                out_hit,
   output logic [5:0]          out_match_length,
   output rule_data_type       out_data
);

   localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

   entry_type mem [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   // latched request
   kind_type            kind_ff;
   logic [KEY_BITS-1:0] addr_ff;
   logic [5:0]          plen_ff;
   rule_data_type       data_ff;

   // scan pipeline
   logic [IdxW-1:0] cnt_ff, cnt_in;
   logic [IdxW-1:0] rd_idx_ff;
   logic            eval_ff;
   entry_type       rd_ff;

   // best candidate and lowest free slot
   logic            found_ff, found_in;
   logic [IdxW-1:0] best_idx_ff, best_idx_in;
   entry_type       best_ff, best_in;
   logic            free_ff, free_in;
   logic [IdxW-1:0] free_idx_ff, free_idx_in;

   // response registers
   logic [1:0]    status_ff;
   logic          hit_ff;
   logic [5:0]    mlen_ff;
   rule_data_type odata_ff;

   logic [KEY_BITS-1:0] key;
   logic                rd_valid, lpm_match, exact_match;
   logic                bad_ins, bad_del, data_same;
   logic [1:0]          status_in;
   logic                do_write;
   logic [IdxW-1:0]     wr_idx;

   assign key       = addr_ff & len_mask(plen_ff);
   assign rd_valid  = valid_ff[rd_idx_ff];
   assign lpm_match = (addr_ff & len_mask(rd_ff.length)) == rd_ff.prefix;
   assign exact_match = (rd_ff.prefix == key) && (rd_ff.length == plen_ff);
   assign stat.last_read = (cnt_ff == LastIdx);

   always_comb begin
      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.load) begin
         found_in = 1'b0;
         free_in  = 1'b0;
      end else if (eval_ff) begin
         if (rd_valid) begin
            if (kind_ff == KIND_LOOKUP) begin
               if (lpm_match && (!found_ff || rd_ff.length > best_ff.length)) begin
                  found_in    = 1'b1;
                  best_idx_in = rd_idx_ff;
                  best_in     = rd_ff;
               end
            end else if (exact_match && !found_ff) begin
               found_in    = 1'b1;
               best_idx_in = rd_idx_ff;
               best_in     = rd_ff;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) cnt_in = '0;
      else if (cmd.read && !stat.last_read) cnt_in = cnt_ff + 1'b1;
   end

   assign bad_ins   = (plen_ff > MAX_V4_LEN) || (data_ff.v6_length > MAX_V6_LEN);
   assign bad_del   = plen_ff > MAX_V4_LEN;
   assign data_same = (best_ff.data.v6_high == data_ff.v6_high)
                   && (best_ff.data.v6_low == data_ff.v6_low)
                   && (best_ff.data.v6_length == data_ff.v6_length)
                   && (best_ff.data.format == data_ff.format)
                   && (best_ff.data.ratio == data_ff.ratio)
                   && (best_ff.data.adjacent == data_ff.adjacent)
                   && (best_ff.data.transport == data_ff.transport);

   // commit decision
   always_comb begin
      valid_in  = valid_ff;
      status_in = ST_OK;
      do_write  = 1'b0;
      wr_idx    = best_idx_ff;
      unique case (kind_ff)
         KIND_LOOKUP: if (!found_ff) status_in = ST_NOT_FOUND;
         KIND_INSERT: begin
            if (bad_ins) status_in = ST_BAD_LEN;
            else if (found_ff) do_write = 1'b1;
            else if (free_ff) begin
               do_write         = 1'b1;
               wr_idx           = free_idx_ff;
               valid_in[wr_idx] = 1'b1;
            end else status_in = ST_FULL;
         end
         KIND_DELETE: begin
            if (bad_del) status_in = ST_BAD_LEN;
            else if (found_ff && data_same) valid_in[best_idx_ff] = 1'b0;
            else status_in = ST_NOT_FOUND;
         end
         KIND_FLUSH: valid_in = '0;
         default: status_in = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         eval_ff  <= 1'b0;
         found_ff <= 1'b0;
         free_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.commit) valid_ff <= valid_in;
         eval_ff  <= cmd.read;
         found_ff <= found_in;
         free_ff  <= free_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind_type'(in_kind);
         addr_ff <= in_address;
         plen_ff <= in_prefix_length;
         data_ff <= in_data;
      end
      rd_ff       <= mem[cnt_ff];
      rd_idx_ff   <= cnt_ff;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      free_idx_ff <= free_idx_in;
      if (cmd.commit && do_write) begin
         mem[wr_idx] <= '{prefix: key, length: plen_ff, data: data_ff};
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         hit_ff    <= (kind_ff == KIND_LOOKUP) && found_ff;
         if ((kind_ff == KIND_LOOKUP) && found_ff) begin
            mlen_ff  <= best_ff.length;
            odata_ff <= best_ff.data;
         end else begin
            mlen_ff  <= '0;
            odata_ff <= '0;
         end
      end
   end

   assign out_status       = status_ff;
   assign out_hit          = hit_ff;
   assign out_match_length = mlen_ff;
   assign out_data         = odata_ff;

endmodule

// File: src/prefix_rule_lpm_table_top.sv
// ----------------------------------------------------------------------------
// prefix_rule_lpm_table_top
// ipv4 longest-prefix-match rule table with insert, delete and flush
// ----------------------------------------------------------------------------
// Each request runs one operation (lookup, insert, delete or flush) and
// returns one response. The table is a flat single-port memory read one
// entry per cycle: the request is latched at the accepting edge, then the
// scan reads all TABLE_DEPTH entries, the drain state empties the read
// register and the commit state writes the result. A new request is
// accepted in the cycle after the commit, so the block takes no new request
// before it is through with the last one. The commit waits while an earlier
// response still sits unaccepted in the output register. Valid bits are
// flops cleared at reset, so no clearing pass is needed.
module prefix_rule_lpm_table_top
   import plt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // address[31:0], prefix_length[37:32], v6_prefix_high[101:38],
   // v6_prefix_low[165:102], v6_length[173:166], share_ratio[189:174],
   // port_adjacent[205:190], addr_format[213:206], transport_mode[221:214],
   // ext_flag[229:222], zero fill above
   input  logic [231:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // match_length[5:0], out_v6_high[69:6], out_v6_low[133:70],
   // out_v6_length[141:134], out_ratio[157:142], out_adjacent[173:158],
   // out_format[181:174], out_transport[189:182], out_extension[197:190],
   // zero fill above
   output logic [199:0] rsp_tdata,
   // status[1:0], hit[2]
   output logic [2:0]   rsp_tuser
);

   cmd_type       cmd;
   stat_type      stat;
   rule_data_type in_data, out_data;
   logic [1:0]    out_status;
   logic          out_hit;
   logic [5:0]    out_mlen;

   // unpack the request payload
   assign in_data.v6_high   = req_tdata[101:38];
   assign in_data.v6_low    = req_tdata[165:102];
   assign in_data.v6_length = req_tdata[173:166];
   assign in_data.ratio     = req_tdata[189:174];
   assign in_data.adjacent  = req_tdata[205:190];
   assign in_data.format    = req_tdata[213:206];
   assign in_data.transport = req_tdata[221:214];
   assign in_data.extension = req_tdata[229:222];

   plt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   plt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .in_kind          (req_tuser),
      .in_address       (req_tdata[31:0]),
      .in_prefix_length (req_tdata[37:32]),
      .in_data          (in_data),
      .out_status       (out_status),
      .out_hit          (out_hit),
      .out_match_length (out_mlen),
      .out_data         (out_data)
   );

   // pack the response payload
   assign rsp_tdata = {2'b00,
                       out_data.extension, out_data.transport, out_data.format,
                       out_data.adjacent, out_data.ratio, out_data.v6_length,
                       out_data.v6_low, out_data.v6_high, out_mlen};
   assign rsp_tuser = {out_hit, out_status};

endmodule

// File: src/plt_checker.sv
// ----------------------------------------------------------------------------
// plt_checker
// port-level checks for the prefix rule table, bound to the top level
// ----------------------------------------------------------------------------
`include "prefix_rule_lpm_table_top_defines.svh"

module plt_checker
   import plt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [199:0] rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   `PLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `PLT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `PLT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `PLT_ASSERT_NOW(a_hit_ok, clock, reset, rsp_tvalid && rsp_tuser[2], rsp_tuser[1:0] == ST_OK)
   `PLT_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser[2], rsp_tdata == '0)

endmodule

bind prefix_rule_lpm_table_top plt_checker u_plt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ipv4 longest-prefix-match rule table
// ----------------------------------------------------------------------------
// Requests go in on the req_ stream and responses come out on the rsp_ stream.
// A behavioral copy of the rule table predicts each response when its request
// is accepted. A monitor compares every response with the oldest prediction.
// The directed tests come first. Random traffic follows, and it runs under
// three idle patterns on the two sides.
module tb_top;
   import plt_pkg::*;

   localparam int DEPTH = 64;
   localparam int LATENCY = DEPTH + 3;
   localparam longint CYCLE_LIMIT = 2000000;

   // response fields, checked one by one
   typedef struct packed {
      status_type  status;
      logic        hit;
      logic [5:0]  match_length;
      logic [63:0] v6_high;
      logic [63:0] v6_low;
      logic [7:0]  v6_length;
      logic [15:0] ratio;
      logic [15:0] adjacent;
      logic [7:0]  format;
      logic [7:0]  transport;
      logic [7:0]  extension;
   } rule_rsp_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [231:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [199:0] rsp_tdata;
   logic [2:0]   rsp_tuser;

   // idle percentages, changed between phases
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned error_count;
   longint      cycle_count;
   int unsigned sent_count;
   int unsigned hit_count;

   // predicted rule table
   logic          tbl_valid  [DEPTH];
   logic [31:0]   tbl_prefix [DEPTH];
   logic [5:0]    tbl_length [DEPTH];
   rule_data_type tbl_data   [DEPTH];

   rule_rsp_type expected_rsps[$];

   // small pool of rule keys, so that lookups and deletes hit often
   logic [31:0]   key_addr [16];
   logic [5:0]    key_len  [16];
   rule_data_type key_data [16];

   prefix_rule_lpm_table_top #(.TABLE_DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] m;
      m = '0;
      for (int b = 0; b < 32; b++)
         if (b < len) m[31-b] = 1'b1;
      return m;
   endfunction

   function automatic int find_rule(input logic [31:0] key, input logic [5:0] len);
      for (int i = 0; i < DEPTH; i++)
         if (tbl_valid[i] && tbl_prefix[i] == key && tbl_length[i] == len) return i;
      return -1;
   endfunction

   // apply one request to the predicted table and return the response
   function automatic rule_rsp_type table_apply(input kind_type kind, input logic [31:0] addr,
                                                input logic [5:0] plen,
                                                input rule_data_type d);
      rule_rsp_type r;
      logic [31:0] key;
      int best;
      r = '0;
      key = addr & prefix_mask(plen);
      best = -1;
      case (kind)
         KIND_LOOKUP: begin
            for (int i = 0; i < DEPTH; i++)
               if (tbl_valid[i] && (addr & prefix_mask(tbl_length[i])) == tbl_prefix[i])
                  if (best < 0 || tbl_length[i] > tbl_length[best]) best = i;
            if (best < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.status = ST_OK;
               r.hit = 1'b1;
               r.match_length = tbl_length[best];
               {r.v6_high, r.v6_low, r.v6_length, r.ratio, r.adjacent, r.format,
                r.transport, r.extension} = tbl_data[best];
            end
         end
         KIND_INSERT: begin
            if (plen > 32 || d.v6_length > 128) begin
               r.status = ST_BAD_LEN;
            end else begin
               best = find_rule(key, plen);
               if (best < 0)
                  for (int i = DEPTH - 1; i >= 0; i--)
                     if (!tbl_valid[i]) best = i;
               if (best < 0) begin
                  r.status = ST_FULL;
               end else begin
                  tbl_valid[best] = 1'b1;
                  tbl_prefix[best] = key;
                  tbl_length[best] = plen;
                  tbl_data[best] = d;
               end
            end
         end
         KIND_DELETE: begin
            if (plen > 32) begin
               r.status = ST_BAD_LEN;
            end else begin
               best = find_rule(key, plen);
               // extension is not part of the delete compare
               if (best < 0 || tbl_data[best].v6_high != d.v6_high
                   || tbl_data[best].v6_low != d.v6_low
                   || tbl_data[best].v6_length != d.v6_length
                   || tbl_data[best].format != d.format
                   || tbl_data[best].ratio != d.ratio
                   || tbl_data[best].adjacent != d.adjacent
                   || tbl_data[best].transport != d.transport)
                  r.status = ST_NOT_FOUND;
               else
                  tbl_valid[best] = 1'b0;
            end
         end
         default: begin
            for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
         end
      endcase
      return r;
   endfunction

   // send one request and queue its predicted response at acceptance
   // valid stays high after acceptance; the next request or the drain drops it
   task automatic send_request(input kind_type kind, input logic [31:0] addr,
                               input logic [5:0] plen, input rule_data_type d);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, d.extension, d.transport, d.format, d.adjacent, d.ratio,
                    d.v6_length, d.v6_low, d.v6_high, plen, addr};
      do @(posedge clock); while (!req_tready);
      expected_rsps.push_back(table_apply(kind, addr, plen, d));
      sent_count++;
   endtask

   function automatic rule_data_type random_data();
      rule_data_type d;
      d.v6_high = {$urandom, $urandom};
      d.v6_low = {$urandom, $urandom};
      d.v6_length = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(128));
      d.ratio = 16'($urandom);
      d.adjacent = 16'($urandom);
      d.format = 8'($urandom);
      d.transport = 8'($urandom);
      d.extension = 8'($urandom);
      return d;
   endfunction

   // response monitor and receiver stall
   always @(posedge clock) begin
      rule_rsp_type got, want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status       = status_type'(rsp_tuser[1:0]);
            got.hit          = rsp_tuser[2];
            got.match_length = rsp_tdata[5:0];
            got.v6_high      = rsp_tdata[69:6];
            got.v6_low       = rsp_tdata[133:70];
            got.v6_length    = rsp_tdata[141:134];
            got.ratio        = rsp_tdata[157:142];
            got.adjacent     = rsp_tdata[173:158];
            got.format       = rsp_tdata[181:174];
            got.transport    = rsp_tdata[189:182];
            got.extension    = rsp_tdata[197:190];
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected");
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.hit) hit_count++;
               if (got.status != want.status) begin
                  $error("status exp %0d got %0d", want.status, got.status); error_count++;
               end
               if (got.hit != want.hit) begin
                  $error("hit exp %0d got %0d", want.hit, got.hit); error_count++;
               end
               if (got.match_length != want.match_length) begin
                  $error("match_length exp %0d got %0d", want.match_length,
                         got.match_length);
                  error_count++;
               end
               if (got.v6_high != want.v6_high) begin
                  $error("out_v6_high exp %h got %h", want.v6_high, got.v6_high);
                  error_count++;
               end
               if (got.v6_low != want.v6_low) begin
                  $error("out_v6_low exp %h got %h", want.v6_low, got.v6_low);
                  error_count++;
               end
               if (got.v6_length != want.v6_length) begin
                  $error("out_v6_length exp %0d got %0d", want.v6_length, got.v6_length);
                  error_count++;
               end
               if (got.ratio != want.ratio) begin
                  $error("out_ratio exp %0d got %0d", want.ratio, got.ratio); error_count++;
               end
               if (got.adjacent != want.adjacent) begin
                  $error("out_adjacent exp %0d got %0d", want.adjacent, got.adjacent);
                  error_count++;
               end
               if (got.format != want.format) begin
                  $error("out_format exp %0d got %0d", want.format, got.format); error_count++;
               end
               if (got.transport != want.transport) begin
                  $error("out_transport exp %0d got %0d", want.transport, got.transport);
                  error_count++;
               end
               if (got.extension != want.extension) begin
                  $error("out_extension exp %0d got %0d", want.extension, got.extension);
                  error_count++;
               end
            end
         end
         rsp_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", expected_rsps.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // extremes of every field and each special case
   task automatic test_directed();
      rule_data_type d, z, m, b;
      z = '0;
      d = random_data();
      d.v6_length = 8'd128;
      m = '1;
      m.v6_length = 8'd128;
      b = random_data();
      b.v6_length = 8'd129;
      send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, z);          // empty table miss
      send_request(KIND_INSERT, 32'hC0A8_01FF, 6'd24, d);         // host bits masked
      send_request(KIND_LOOKUP, 32'hC0A8_0107, 6'd0, z);
      send_request(KIND_INSERT, 32'h0000_0000, 6'd0, m);          // default route, max data
      send_request(KIND_INSERT, 32'h0, 6'd0, b);                  // bad v6 length
      send_request(KIND_INSERT, 32'hFFFF_FFFF, 6'd32, z);         // host route, zero data
      send_request(KIND_INSERT, 32'h1, 6'd33, z);                 // v4 too long
      send_request(KIND_INSERT, 32'h1, 6'd63, z);
      send_request(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, z);          // longest wins
      send_request(KIND_LOOKUP, 32'h0102_0304, 6'd0, z);          // default hit
      d.v6_high = ~d.v6_high;
      send_request(KIND_INSERT, 32'hC0A8_0100, 6'd24, d);         // overwrite
      send_request(KIND_LOOKUP, 32'hC0A8_01AA, 6'd0, z);
      send_request(KIND_DELETE, 32'hC0A8_0100, 6'd40, d);         // bad length
      send_request(KIND_DELETE, 32'hC0A8_0100, 6'd24, z);         // data mismatch
      d.extension = ~d.extension;
      send_request(KIND_DELETE, 32'hC0A8_01FF, 6'd24, d);         // extension ignored
      send_request(KIND_DELETE, 32'hC0A8_0100, 6'd24, d);         // now absent
      send_request(KIND_FLUSH, 32'hFFFF_FFFF, 6'h3F, '1);
      send_request(KIND_LOOKUP, 32'h0, 6'd0, z);
      // fill the table, then one more
      for (int i = 0; i <= DEPTH; i++) send_request(KIND_INSERT, i << 8, 6'd24, z);
      send_request(KIND_INSERT, 32'h0000_3F00, 6'd24, d);         // update in a full table
      send_request(KIND_LOOKUP, 32'h0000_3F11, 6'd0, z);
      send_request(KIND_FLUSH, 32'h0, 6'd0, z);
   endtask

   // random traffic around a small pool of rules
   task automatic test_random(input int count);
      kind_type kind;
      logic [31:0] addr;
      logic [5:0] plen;
      rule_data_type d;
      int k, sel;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(15);
         sel = $urandom_range(99);
         d = key_data[k];
         plen = key_len[k];
         addr = key_addr[k] | ($urandom & ~prefix_mask(plen));
         if (sel < 40) begin
            kind = KIND_LOOKUP;
            if ($urandom_range(3) == 0) addr = $urandom;
         end else if (sel < 70) begin
            kind = KIND_INSERT;
            if ($urandom_range(2) == 0) begin
               d = random_data();
               key_data[k] = d;
            end
            if ($urandom_range(29) == 0) plen = 6'($urandom);
         end else if (sel < 97) begin
            kind = KIND_DELETE;
            if ($urandom_range(3) == 0) d = random_data();
            d.extension = 8'($urandom);
            if ($urandom_range(29) == 0) plen = 6'($urandom);
         end else begin
            kind = KIND_FLUSH;
         end
         send_request(kind, addr, plen, d);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = KIND_LOOKUP;
      rsp_tready = 1'b0;
      error_count = 0;
      cycle_count = 0;
      sent_count = 0;
      hit_count = 0;
      send_idle_pct = 37;
      recv_idle_pct = 56;
      for (int i = 0; i < DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_prefix[i] = '0;
         tbl_length[i] = '0;
         tbl_data[i] = '0;
      end
      for (int k = 0; k < 16; k++) begin
         key_len[k] = (k < 3) ? 6'(k * 16) : 6'($urandom_range(32));
         key_addr[k] = (k < 8 ? 32'hC0A8_0000 : $urandom) & prefix_mask(key_len[k]);
         key_data[k] = random_data();
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(470);
      wait_drained();
      send_idle_pct = 56;
      recv_idle_pct = 37;
      test_random(470);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(470);
      wait_drained();
      $display("sent %0d requests, %0d lookup hits, across three idle patterns",
               sent_count, hit_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
